// File: design/acm_pkg.sv
// constants, codes and helpers shared by the multi-pattern matcher
// no dependencies
package acm_pkg;

  localparam int NODES        = 4096;
  localparam int ALPHABET     = 26;
  localparam int MAX_PATTERNS = 1024;

  localparam int NODE_W     = 12;
  localparam int SYM_W      = 5;
  localparam int ID_W       = 11;
  localparam int CNT_W      = 11;
  localparam int TAG_W      = 10;
  localparam int FREE_W     = 13;
  localparam int SEEN_AW    = 10;
  localparam int GOTO_DEPTH = NODES * ALPHABET;
  localparam int GOTO_AW    = $clog2(GOTO_DEPTH);

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_BUILD   = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_FULL   = 2'd1;
  localparam status_t ST_BAD_ID = 2'd2;
  localparam status_t ST_UNUSED = 2'd3;

  function automatic logic [GOTO_AW-1:0] edge_addr(input logic [NODE_W-1:0] node,
                                                   input logic [SYM_W-1:0] sym);
    logic [GOTO_AW-1:0] base;
    base = GOTO_AW'(node * ALPHABET);
    return base + GOTO_AW'(sym);
  endfunction

endpackage

// File: design/acm_in_if.sv
// input channel of the matcher: valid/ready with one item payload
// depends on acm_pkg
interface acm_in_if;
  import acm_pkg::*;
  logic                valid;
  logic                ready;
  op_t                 op;
  logic [SYM_W-1:0]    symbol;
  logic [ID_W-1:0]     pattern_id;
  logic                last_symbol;

  modport source (output valid, op, symbol, pattern_id, last_symbol, input ready);
  modport sink   (input valid, op, symbol, pattern_id, last_symbol, output ready);
endinterface

// File: design/acm_out_if.sv
// result channel of the matcher: valid/ready with match count and status
// depends on acm_pkg
interface acm_out_if;
  import acm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  match_count;
  status_t           status;

  modport source (output valid, match_count, status, input ready);
  modport sink   (input valid, match_count, status, output ready);
endinterface

// File: design/aho_corasick_multi_pattern_matcher_core.sv
// aho-corasick matcher core: sequencer over goto, link, count, tag, seen and queue rams
// depends on acm_pkg, acm_in_if, acm_out_if, acm_ram
//
// usage: items arrive on in_ch (valid/ready), one result per item leaves on out_ch.
// op clear empties the automaton, op pattern adds one pattern symbol, op build
// completes goto edges and output links, op text advances the scan and reports
// the running match count (reset after a text's last symbol).
// a pattern symbol reads one goto edge and writes it if it is new; a text symbol
// follows the output links in turn, stopping at a pattern already seen; build reads each
// root edge, then every symbol's edge of each trie node in queue order. a result state
// loads the output register, and the next item is accepted in the idle state that follows.
// after reset and after a clear a clearing pass writes zeros through the goto
// ram, one entry a cycle, with in_ch.ready low; a clear's result follows the pass.
// a result waits in the output register while the receiver stalls; the next item
// is accepted meanwhile, and its result waits for the slot.
// a full trie gives status 1, a bad pattern number status 2; the item changes nothing.
module aho_corasick_multi_pattern_matcher_core (
  input  logic clk,
  input  logic rst_n,
  acm_in_if.sink    in_ch,
  acm_out_if.source out_ch
);
  import acm_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_P_RD, S_P_EV, S_P_CNT,
    S_B_RR, S_B_RW, S_B_POP, S_B_X, S_B_XF, S_B_E0, S_B_E1, S_B_E2, S_B_FIN, S_B_F1,
    S_T_G, S_T_P, S_T_T, S_T_S, S_RES
  } state_t;

  state_t              state_r;
  logic [GOTO_AW-1:0]  clr_r;
  logic                clr_res_r;
  op_t                 op_r;
  logic [SYM_W-1:0]    sym_r;
  logic [ID_W-1:0]     id_r;
  logic                last_r;
  status_t             st_r;
  logic [FREE_W-1:0]   free_r;
  logic [NODE_W-1:0]   ins_r, scan_r, n_r, x_r, xf_r, c_r;
  logic [NODE_W-1:0]   lnk_r;
  logic [CNT_W-1:0]    run_r, cnt_r;
  logic [TAG_W-1:0]    tag_r;
  logic                built_r;
  logic [SYM_W-1:0]    i_r;
  logic [FREE_W-1:0]   head_r, tail_r;
  logic                out_valid_r;
  logic [CNT_W-1:0]    out_count_r;
  status_t             out_status_r;

  logic                   g_we, g_re;
  logic [GOTO_AW-1:0]     g_wa, g_ra;
  logic [NODE_W-1:0]      g_wd, g_rd;
  logic                   lk_we, lk_re, ct_we, ct_re, tg_we, tg_re, qu_we, qu_re;
  logic [NODE_W-1:0]      lk_wa, lk_ra, ct_wa, ct_ra, tg_wa, tg_ra, qu_wa, qu_ra;
  logic [NODE_W-1:0]      lk_wd, lk_rd, qu_wd, qu_rd;
  logic [CNT_W-1:0]       ct_wd, ct_rd;
  logic [TAG_W-1:0]       tg_wd, tg_rd;
  logic                   sn_we, sn_re, sn_wd, sn_rd;
  logic [SEEN_AW-1:0]     sn_wa, sn_ra;

  logic               in_xfer;
  logic               bad_id, p_go, t_go;
  logic [NODE_W-1:0]  n_new, p_sel;
  logic               full;
  logic               q_room;
  logic [CNT_W:0]     run_sum;
  logic [CNT_W-1:0]   run_sat;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_xfer            = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_count = out_count_r;
  assign out_ch.status      = out_status_r;

  assign bad_id = (in_ch.pattern_id == '0) || (in_ch.pattern_id > ID_W'(MAX_PATTERNS));
  assign p_go   = (in_ch.symbol < SYM_W'(ALPHABET)) && !built_r &&
                  !(in_ch.last_symbol && bad_id);
  assign t_go   = (in_ch.symbol < SYM_W'(ALPHABET));
  assign full   = (g_rd == '0) && (free_r >= FREE_W'(NODES));
  assign n_new  = (g_rd == '0) ? free_r[NODE_W-1:0] : g_rd;
  assign p_sel  = (ct_rd != '0) ? n_r : lk_rd;
  assign q_room = (tail_r < FREE_W'(NODES));
  assign run_sum = {1'b0, run_r} + {1'b0, cnt_r};
  assign run_sat = (run_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : run_sum[CNT_W-1:0];

  // memory port control
  always_comb begin
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_re = 1'b0; g_ra = '0;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_re = 1'b0; lk_ra = '0;
    ct_we = 1'b0; ct_wa = '0; ct_wd = '0; ct_re = 1'b0; ct_ra = '0;
    tg_we = 1'b0; tg_wa = '0; tg_wd = '0; tg_re = 1'b0; tg_ra = '0;
    qu_we = 1'b0; qu_wa = '0; qu_wd = '0; qu_re = 1'b0; qu_ra = '0;
    sn_we = 1'b0; sn_wa = '0; sn_wd = 1'b0; sn_re = 1'b0; sn_ra = '0;
    case (state_r)
      S_CLR: begin
        g_we = 1'b1;
        g_wa = clr_r;
        if (clr_r < GOTO_AW'(NODES)) begin
          lk_we = 1'b1; lk_wa = clr_r[NODE_W-1:0];
          ct_we = 1'b1; ct_wa = clr_r[NODE_W-1:0];
          tg_we = 1'b1; tg_wa = clr_r[NODE_W-1:0];
        end
        if (clr_r < GOTO_AW'(MAX_PATTERNS)) begin
          sn_we = 1'b1; sn_wa = clr_r[SEEN_AW-1:0];
        end
      end
      S_IDLE: begin
        if (in_xfer && in_ch.op == OP_PATTERN && p_go) begin
          g_re = 1'b1; g_ra = edge_addr(ins_r, in_ch.symbol);
        end else if (in_xfer && in_ch.op == OP_TEXT && t_go) begin
          g_re = 1'b1; g_ra = edge_addr(scan_r, in_ch.symbol);
        end
      end
      S_P_EV: begin
        if (!full) begin
          if (g_rd == '0) begin
            g_we = 1'b1; g_wa = edge_addr(ins_r, sym_r); g_wd = n_new;
          end
          if (last_r) begin
            ct_re = 1'b1; ct_ra = n_new;
          end
        end
      end
      S_P_CNT: begin
        ct_we = 1'b1; ct_wa = n_r;
        ct_wd = (ct_rd == COUNT_MAX) ? ct_rd : ct_rd + 1'b1;
        tg_we = 1'b1; tg_wa = n_r;
        tg_wd = TAG_W'(id_r - 1'b1);
      end
      S_B_RR: begin
        g_re = 1'b1; g_ra = GOTO_AW'(i_r);
      end
      S_B_RW: begin
        if (g_rd != '0 && q_room) begin
          qu_we = 1'b1; qu_wa = tail_r[NODE_W-1:0]; qu_wd = g_rd;
        end
      end
      S_B_POP: begin
        if (head_r != tail_r) begin
          qu_re = 1'b1; qu_ra = head_r[NODE_W-1:0];
        end
      end
      S_B_X: begin
        lk_re = 1'b1; lk_ra = qu_rd;
      end
      S_B_E0: begin
        g_re = 1'b1; g_ra = edge_addr(x_r, i_r);
      end
      S_B_E1: begin
        g_re = 1'b1; g_ra = edge_addr(xf_r, i_r);
      end
      S_B_E2: begin
        if (c_r == '0) begin
          g_we = 1'b1; g_wa = edge_addr(x_r, i_r); g_wd = g_rd;
        end else begin
          lk_we = 1'b1; lk_wa = c_r; lk_wd = g_rd;
          if (q_room) begin
            qu_we = 1'b1; qu_wa = tail_r[NODE_W-1:0]; qu_wd = c_r;
          end
        end
      end
      S_B_FIN: begin
        ct_re = 1'b1; ct_ra = xf_r;
        lk_re = 1'b1; lk_ra = xf_r;
      end
      S_B_F1: begin
        lk_we = 1'b1; lk_wa = x_r;
        lk_wd = (ct_rd != '0) ? xf_r : lk_rd;
      end
      S_T_G: begin
        ct_re = 1'b1; ct_ra = g_rd;
        lk_re = 1'b1; lk_ra = g_rd;
      end
      S_T_P: begin
        if (p_sel != '0) begin
          tg_re = 1'b1; tg_ra = p_sel;
          ct_re = 1'b1; ct_ra = p_sel;
          lk_re = 1'b1; lk_ra = p_sel;
        end
      end
      S_T_T: begin
        sn_re = 1'b1; sn_ra = tg_rd;
      end
      S_T_S: begin
        if (!sn_rd) begin
          sn_we = 1'b1; sn_wa = tag_r; sn_wd = 1'b1;
          if (lnk_r != '0) begin
            tg_re = 1'b1; tg_ra = lnk_r;
            ct_re = 1'b1; ct_ra = lnk_r;
            lk_re = 1'b1; lk_ra = lnk_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_res_r   <= 1'b0;
      free_r      <= FREE_W'(1);
      ins_r       <= '0;
      scan_r      <= '0;
      run_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_CLEAR;
      last_r      <= 1'b0;
      st_r        <= ST_OK;
    end else begin
      if (state_r == S_RES && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == GOTO_AW'(GOTO_DEPTH - 1)) begin
            st_r    <= ST_OK;
            state_r <= clr_res_r ? S_RES : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            op_r   <= in_ch.op;
            sym_r  <= in_ch.symbol;
            id_r   <= in_ch.pattern_id;
            last_r <= in_ch.last_symbol;
            st_r   <= ST_OK;
            case (in_ch.op)
              OP_CLEAR: begin
                free_r    <= FREE_W'(1);
                ins_r     <= '0;
                scan_r    <= '0;
                run_r     <= '0;
                built_r   <= 1'b0;
                clr_r     <= '0;
                clr_res_r <= 1'b1;
                state_r   <= S_CLR;
              end
              OP_PATTERN: begin
                if (p_go) begin
                  state_r <= S_P_RD;
                end else begin
                  if (!(in_ch.symbol >= SYM_W'(ALPHABET) || built_r)) begin
                    st_r <= ST_BAD_ID;
                  end
                  state_r <= S_RES;
                end
              end
              OP_BUILD: begin
                i_r     <= '0;
                head_r  <= '0;
                tail_r  <= '0;
                state_r <= built_r ? S_RES : S_B_RR;
              end
              OP_TEXT: begin
                state_r <= t_go ? S_T_G : S_RES;
              end
              default: begin
                state_r <= S_RES;
              end
            endcase
          end
        end
        S_P_RD: begin
          state_r <= S_P_EV;
        end
        S_P_EV: begin
          if (full) begin
            st_r    <= ST_FULL;
            state_r <= S_RES;
          end else begin
            if (g_rd == '0) begin
              free_r <= free_r + 1'b1;
            end
            n_r <= n_new;
            if (last_r) begin
              state_r <= S_P_CNT;
            end else begin
              ins_r   <= n_new;
              state_r <= S_RES;
            end
          end
        end
        S_P_CNT: begin
          ins_r   <= '0;
          state_r <= S_RES;
        end
        S_B_RR: begin
          state_r <= S_B_RW;
        end
        S_B_RW: begin
          if (g_rd != '0 && q_room) begin
            tail_r <= tail_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
          state_r <= (i_r == SYM_W'(ALPHABET - 1)) ? S_B_POP : S_B_RR;
        end
        S_B_POP: begin
          if (head_r == tail_r) begin
            built_r <= 1'b1;
            state_r <= S_RES;
          end else begin
            head_r  <= head_r + 1'b1;
            state_r <= S_B_X;
          end
        end
        S_B_X: begin
          x_r     <= qu_rd;
          state_r <= S_B_XF;
        end
        S_B_XF: begin
          xf_r    <= lk_rd;
          i_r     <= '0;
          state_r <= S_B_E0;
        end
        S_B_E0: begin
          state_r <= S_B_E1;
        end
        S_B_E1: begin
          c_r     <= g_rd;
          state_r <= S_B_E2;
        end
        S_B_E2: begin
          if (c_r != '0 && q_room) begin
            tail_r <= tail_r + 1'b1;
          end
          i_r <= i_r + 1'b1;
          state_r <= (i_r == SYM_W'(ALPHABET - 1)) ? S_B_FIN : S_B_E0;
        end
        S_B_FIN: begin
          state_r <= S_B_F1;
        end
        S_B_F1: begin
          state_r <= S_B_POP;
        end
        S_T_G: begin
          scan_r  <= g_rd;
          n_r     <= g_rd;
          state_r <= S_T_P;
        end
        S_T_P: begin
          state_r <= (p_sel != '0) ? S_T_T : S_RES;
        end
        S_T_T: begin
          tag_r   <= tg_rd;
          cnt_r   <= ct_rd;
          lnk_r   <= lk_rd;
          state_r <= S_T_S;
        end
        S_T_S: begin
          if (sn_rd) begin
            state_r <= S_RES;
          end else begin
            run_r   <= run_sat;
            state_r <= (lnk_r != '0) ? S_T_T : S_RES;
          end
        end
        S_RES: begin
          if (!out_valid_r || out_ch.ready) begin
            out_count_r  <= run_r;
            out_status_r <= st_r;
            if (op_r == OP_TEXT && last_r) begin
              run_r  <= '0;
              scan_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  acm_ram #(.WIDTH(NODE_W), .DEPTH(GOTO_DEPTH)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .re(g_re), .raddr(g_ra), .rdata(g_rd)
  );
  acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .re(lk_re), .raddr(lk_ra),
    .rdata(lk_rd)
  );
  acm_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_count (
    .clk(clk), .we(ct_we), .waddr(ct_wa), .wdata(ct_wd), .re(ct_re), .raddr(ct_ra),
    .rdata(ct_rd)
  );
  acm_ram #(.WIDTH(TAG_W), .DEPTH(NODES)) u_tag (
    .clk(clk), .we(tg_we), .waddr(tg_wa), .wdata(tg_wd), .re(tg_re), .raddr(tg_ra),
    .rdata(tg_rd)
  );
  acm_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_queue (
    .clk(clk), .we(qu_we), .waddr(qu_wa), .wdata(qu_wd), .re(qu_re), .raddr(qu_ra),
    .rdata(qu_rd)
  );
  acm_ram #(.WIDTH(1), .DEPTH(MAX_PATTERNS)) u_seen (
    .clk(clk), .we(sn_we), .waddr(sn_wa), .wdata(sn_wd), .re(sn_re), .raddr(sn_ra),
    .rdata(sn_rd)
  );
endmodule

// File: design/acm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module acm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: design/acm_checker.sv
// port-level assertions for the matcher core, bound into the matcher core
// depends on acm_pkg and aho_corasick_multi_pattern_matcher_core
module acm_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input acm_pkg::status_t out_status
);
  import acm_pkg::*;

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != ST_UNUSED)
    else $error("unused status code");

  // one item at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // clearing pass after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("activity right after reset");
endmodule

bind aho_corasick_multi_pattern_matcher_core acm_checker u_acm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_status(out_ch.status)
);
